[rtl/core/console_line_edit_buffer_defines.svh]
// Assertion macros shared by the console line buffer RTL.
`ifndef CONSOLE_LINE_EDIT_BUFFER_DEFINES_SVH
`define CONSOLE_LINE_EDIT_BUFFER_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define CLEB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CLEB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/cleb_pkg.sv]
package cleb_pkg;

	localparam int BUF_DEPTH  = 128;
	localparam int RING_SPAN  = 2 * BUF_DEPTH;
	localparam int ADDR_W     = $clog2(BUF_DEPTH);
	localparam int IDX_W      = $clog2(RING_SPAN);
	localparam int CNT_W      = (IDX_W > 8) ? IDX_W : 8;

	localparam logic [1:0] OP_RX    = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	localparam logic [1:0] RS_NONE  = 2'd0;
	localparam logic [1:0] RS_BYTE  = 2'd1;
	localparam logic [1:0] RS_EMPTY = 2'd2;
	localparam logic [1:0] RS_EOF   = 2'd3;

	localparam logic [7:0] KEY_BS     = 8'h08;
	localparam logic [7:0] KEY_DEL    = 8'h7f;
	localparam logic [7:0] KEY_CTRL_U = 8'h15;
	localparam logic [7:0] KEY_CTRL_C = 8'h03;
	localparam logic [7:0] KEY_CTRL_D = 8'h04;
	localparam logic [7:0] KEY_CR     = 8'h0d;
	localparam logic [7:0] KEY_LF     = 8'h0a;
	localparam logic [7:0] KEY_NONE   = 8'hff;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic       en;
		addr_t      addr;
		logic [7:0] data;
	} cleb_wr_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} cleb_rd_t;

	function automatic idx_t ring_next(idx_t i);
		return (i == IDX_W'(RING_SPAN - 1)) ? '0 : i + idx_t'(1);
	endfunction

	function automatic idx_t ring_prev(idx_t i);
		return (i == '0) ? IDX_W'(RING_SPAN - 1) : i - idx_t'(1);
	endfunction

	function automatic addr_t ring_addr(idx_t i);
		return (i >= IDX_W'(BUF_DEPTH)) ? ADDR_W'(i - IDX_W'(BUF_DEPTH)) : ADDR_W'(i);
	endfunction

	function automatic idx_t ring_dist(idx_t from, idx_t to);
		return (to >= from) ? to - from : to + IDX_W'(RING_SPAN) - from;
	endfunction

endpackage

[rtl/core/cleb_store.sv]
module cleb_store
	import cleb_pkg::*;
(
	input  logic       clk,
	input  cleb_wr_t   wr,
	input  cleb_rd_t   rd,
	output logic [7:0] rdata
);

	logic [7:0] mem [BUF_DEPTH];
	logic [7:0] rdata_q;

	// A read that hits the entry written in the same cycle returns the new byte.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			if (wr.en && (wr.addr == rd.addr)) begin
				rdata_q <= wr.data;
			end else begin
				rdata_q <= mem[rd.addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/console_line_edit_buffer.sv]
// Console line buffer with editing. Items arrive on the req channel (req_valid,
// req_ready) as opcode, data_byte and first_of_read: a received byte, a reader
// request for one committed byte, or a byte from a writer. Each item gives
// exactly one result on the rsp channel (rsp_valid, rsp_ready): echo, erase
// count, read status and byte, line end and kill request.
// An accepted item is registered in the input register, processed there against
// the ring indices and the byte store, and its result is registered in the result
// register, which presents it. One item is accepted per cycle while the receiver does not stall.
// The store read for a reader request is issued at acceptance; its address
// comes from the read index as left by the item ahead of it.
// Reset clears the read, commit and edit indices, leaving the ring empty; the
// store itself is not cleared, as only committed bytes are ever read.
// When the receiver stalls, the result register holds its item, the item behind
// it waits in the input register, and req_ready drops until rsp_ready returns.
`include "console_line_edit_buffer_defines.svh"

module console_line_edit_buffer
	import cleb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] data_byte,
	input  logic       first_of_read,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic       echo_valid,
	output logic [7:0] echo_byte,
	output logic [7:0] erase_count,
	output logic [1:0] read_status,
	output logic [7:0] read_byte,
	output logic       line_end,
	output logic       kill_request
);

	idx_t       read_q, commit_q, edit_q;
	idx_t       read_n, commit_n, edit_n;
	idx_t       dist_ce, dist_re;
	logic       s1_valid_q;
	logic [1:0] op_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       rsp_valid_q;
	logic       advance, s1_fire, req_fire;
	logic [7:0] rdata;
	logic [7:0] ch;
	logic [CNT_W-1:0] dist_ext;
	cleb_wr_t   wr;
	cleb_rd_t   rd;

	logic       echo_v, lend, kill;
	logic [7:0] echo_b, erase, rbyte;
	logic [1:0] rstat;

	logic       echo_valid_q, line_end_q, kill_request_q;
	logic [7:0] echo_byte_q, erase_count_q, read_byte_q;
	logic [1:0] read_status_q;

	assign advance   = !rsp_valid_q || rsp_ready;
	assign s1_fire   = s1_valid_q && advance;
	assign req_ready = !s1_valid_q || advance;
	assign req_fire  = req_valid && req_ready;

	assign dist_ce  = ring_dist(commit_q, edit_q);
	assign dist_re  = ring_dist(read_q, edit_q);
	assign dist_ext = CNT_W'(dist_ce);
	assign ch       = (byte_s1 == KEY_CR) ? KEY_LF : byte_s1;

	always_comb begin
		read_n   = read_q;
		commit_n = commit_q;
		edit_n   = edit_q;
		echo_v   = 1'b0;
		echo_b   = '0;
		erase    = '0;
		rstat    = RS_NONE;
		rbyte    = '0;
		lend     = 1'b0;
		kill     = 1'b0;
		wr.en    = 1'b0;
		wr.addr  = ring_addr(edit_q);
		wr.data  = ch;
		unique case (op_s1)
			OP_RX: begin
				priority if (byte_s1 == KEY_NONE) begin
					kill = 1'b0;
				end else if (byte_s1 == KEY_BS || byte_s1 == KEY_DEL) begin
					if (edit_q != commit_q) begin
						edit_n = ring_prev(edit_q);
						erase  = 8'd1;
					end
				end else if (byte_s1 == KEY_CTRL_U) begin
					erase  = (dist_ext > CNT_W'(255)) ? 8'hff : dist_ext[7:0];
					edit_n = commit_q;
				end else if (byte_s1 == KEY_CTRL_C) begin
					kill = 1'b1;
				end else begin
					if (dist_re != IDX_W'(BUF_DEPTH)) begin
						wr.en  = s1_fire;
						edit_n = ring_next(edit_q);
						echo_v = 1'b1;
						echo_b = ch;
						if (ch == KEY_LF || ch == KEY_CTRL_D) begin
							commit_n = ring_next(edit_q);
						end
					end
				end
			end
			OP_READ: begin
				priority if (read_q == commit_q) begin
					rstat = RS_EMPTY;
				end else if (rdata == KEY_CTRL_D) begin
					rstat = RS_EOF;
					if (first_s1) begin
						read_n = ring_next(read_q);
					end
				end else begin
					rstat  = RS_BYTE;
					rbyte  = rdata;
					lend   = (rdata == KEY_LF);
					read_n = ring_next(read_q);
				end
			end
			OP_WRITE: begin
				if (byte_s1 == KEY_BS) begin
					erase = 8'd1;
				end else begin
					echo_v = 1'b1;
					echo_b = byte_s1;
				end
			end
			default: begin
				kill = 1'b0;
			end
		endcase
	end

	assign rd.en   = req_fire && (opcode == OP_READ);
	assign rd.addr = ring_addr(s1_fire ? read_n : read_q);

	cleb_store u_store (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_q      <= '0;
			commit_q    <= '0;
			edit_q      <= '0;
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (s1_fire) begin
				read_q   <= read_n;
				commit_q <= commit_n;
				edit_q   <= edit_n;
			end
			if (req_ready) begin
				s1_valid_q <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1    <= opcode;
			byte_s1  <= data_byte;
			first_s1 <= first_of_read;
		end
		if (s1_fire) begin
			echo_valid_q   <= echo_v;
			echo_byte_q    <= echo_b;
			erase_count_q  <= erase;
			read_status_q  <= rstat;
			read_byte_q    <= rbyte;
			line_end_q     <= lend;
			kill_request_q <= kill;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign echo_valid   = echo_valid_q;
	assign echo_byte    = echo_byte_q;
	assign erase_count  = erase_count_q;
	assign read_status  = read_status_q;
	assign read_byte    = read_byte_q;
	assign line_end     = line_end_q;
	assign kill_request = kill_request_q;

	`CLEB_ASSERT(a_ring_bound, dist_re <= IDX_W'(BUF_DEPTH), "Ring holds more than its depth.")
	`CLEB_ASSERT(a_commit_order, ring_dist(read_q, commit_q) <= dist_re, "Commit past edit.")
	`CLEB_ASSERT_NEXT(a_accept_load, req_fire, s1_valid_q, "Accepted item not in input register.")
	`CLEB_ASSERT_NEXT(a_result_load, s1_fire, rsp_valid_q, "Processed item gave no result.")

endmodule
